[rtl/core/ppit_pkg.sv]
// Shared constants and types of the point-in-polygon test block.
package ppit_pkg;

	localparam int MAX_VERTICES      = 256;
	localparam int COORD_BITS        = 16;
	localparam int ADDR_BITS         = $clog2(MAX_VERTICES);
	localparam int CNT_BITS          = ADDR_BITS + 1;
	localparam int DIFF_BITS         = COORD_BITS + 1;
	localparam int PROD_BITS         = 2 * DIFF_BITS;
	localparam int KIND_BITS         = 2;
	localparam int MIN_POLY_VERTICES = 2;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_TEST   = 2'd2
	} kind_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vertex_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_LAST,
		ST_RD_FIRST,
		ST_CHECK,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

[rtl/core/ppit_in_if.sv]
// Input channel: command kind and point coordinates.
interface ppit_in_if;
	logic                          valid;
	logic                          ready;
	logic [ppit_pkg::KIND_BITS-1:0] kind;
	ppit_pkg::coord_t              point_x;
	ppit_pkg::coord_t              point_y;

	modport source (output valid, output kind, output point_x, output point_y, input ready);
	modport sink (input valid, input kind, input point_x, input point_y, output ready);
endinterface

[rtl/core/ppit_out_if.sv]
// Result channel: inside flag and sticky overflow flag.
interface ppit_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic overflowed;

	modport source (output valid, output inside_res, output overflowed, input ready);
	modport sink (input valid, input inside_res, input overflowed, output ready);
endinterface

[rtl/core/polygon_point_in_test_core.sv]
// Point-in-polygon test core: vertex memory, edge walk and crossing parity.
//
// The block stores up to 256 vertices in a synchronous memory with one write
// port and one read port and answers point tests with the even-odd crossing
// rule. A clear or an append item is accepted while idle and leaves the block
// idle. A test item with at least two stored vertices reads the last and the
// first vertex, then walks the edges, reading one vertex per cycle through the
// memory's single read port, and ends in a two-stage multiply-and-compare
// drain. A test with fewer than two vertices skips the walk. Appends beyond
// capacity are dropped and set a sticky overflow flag that every result
// reports until the next clear. A result waiting at the output does not stop
// clears and appends from being accepted.
module polygon_point_in_test_core (
	input  logic        clk,
	input  logic        arst_n,
	ppit_in_if.sink     req,
	ppit_out_if.source  rsp
);

	ppit_pkg::state_t  state_q;
	ppit_pkg::state_t  state_d;

	ppit_pkg::vertex_t vert_mem_q [ppit_pkg::MAX_VERTICES];
	ppit_pkg::vertex_t rdata_q;
	logic [ppit_pkg::ADDR_BITS-1:0] rd_addr;

	logic [ppit_pkg::CNT_BITS-1:0] count_q;
	logic [ppit_pkg::CNT_BITS-1:0] neff_q;
	logic [ppit_pkg::CNT_BITS-1:0] walk_q;
	logic [ppit_pkg::CNT_BITS-1:0] last_cnt;
	logic                          ovf_q;

	ppit_pkg::vertex_t pt_q;
	ppit_pkg::vertex_t last_q;
	ppit_pkg::vertex_t prev_q;

	logic accept;
	logic is_test;
	logic load_out;

	logic                                 vld_s1_q;
	logic                                 vld_s2;
	logic                                 cross_s2;
	logic                                 dypos_s2;
	logic signed [ppit_pkg::PROD_BITS-1:0] p1_s2;
	logic signed [ppit_pkg::PROD_BITS-1:0] p2_s2;

	logic signed [ppit_pkg::DIFF_BITS-1:0] dx_pt;
	logic signed [ppit_pkg::DIFF_BITS-1:0] dy_edge;
	logic signed [ppit_pkg::DIFF_BITS-1:0] dx_edge;
	logic signed [ppit_pkg::DIFF_BITS-1:0] dy_pt;
	logic                                 straddle;
	logic                                 hit;
	logic                                 parity_q;

	logic out_valid_q;
	logic inside_q;
	logic ovf_out_q;

	ppit_pkg::coord_t x0, y0, x1, y1, px, py;

	assign req.ready      = (state_q == ppit_pkg::ST_IDLE);
	assign accept         = req.valid && req.ready;
	assign is_test        = accept && (req.kind == ppit_pkg::KIND_TEST);
	assign last_cnt       = count_q - ppit_pkg::CNT_BITS'(1);

	assign rsp.valid      = out_valid_q;
	assign rsp.inside_res = inside_q;
	assign rsp.overflowed = ovf_out_q;

	always_comb begin
		state_d  = state_q;
		rd_addr  = '0;
		load_out = 1'b0;
		case (state_q)
			ppit_pkg::ST_IDLE: begin
				if (is_test) begin
					if (count_q < ppit_pkg::CNT_BITS'(ppit_pkg::MIN_POLY_VERTICES)) begin
						state_d = ppit_pkg::ST_DONE;
					end else begin
						state_d = ppit_pkg::ST_RD_LAST;
					end
				end
			end
			ppit_pkg::ST_RD_LAST: begin
				rd_addr = last_cnt[ppit_pkg::ADDR_BITS-1:0];
				state_d = ppit_pkg::ST_RD_FIRST;
			end
			ppit_pkg::ST_RD_FIRST: begin
				state_d = ppit_pkg::ST_CHECK;
			end
			ppit_pkg::ST_CHECK: begin
				state_d = ppit_pkg::ST_WALK;
			end
			ppit_pkg::ST_WALK: begin
				if (walk_q != neff_q) begin
					rd_addr = walk_q[ppit_pkg::ADDR_BITS-1:0];
				end
				if (walk_q == neff_q) begin
					state_d = ppit_pkg::ST_DRAIN;
				end
			end
			ppit_pkg::ST_DRAIN: begin
				if (!vld_s1_q && !vld_s2) begin
					state_d = ppit_pkg::ST_DONE;
				end
			end
			ppit_pkg::ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ppit_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ppit_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppit_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.kind == ppit_pkg::KIND_APPEND)
			&& (count_q < ppit_pkg::CNT_BITS'(ppit_pkg::MAX_VERTICES))) begin
			vert_mem_q[count_q[ppit_pkg::ADDR_BITS-1:0]] <= '{x: req.point_x, y: req.point_y};
		end
		rdata_q <= vert_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			case (req.kind)
				ppit_pkg::KIND_CLEAR: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
				ppit_pkg::KIND_APPEND: begin
					if (count_q < ppit_pkg::CNT_BITS'(ppit_pkg::MAX_VERTICES)) begin
						count_q <= count_q + ppit_pkg::CNT_BITS'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign x0 = prev_q.x;
	assign y0 = prev_q.y;
	assign x1 = rdata_q.x;
	assign y1 = rdata_q.y;
	assign px = pt_q.x;
	assign py = pt_q.y;

	assign dx_pt    = ppit_pkg::DIFF_BITS'(px) - ppit_pkg::DIFF_BITS'(x0);
	assign dy_edge  = ppit_pkg::DIFF_BITS'(y1) - ppit_pkg::DIFF_BITS'(y0);
	assign dx_edge  = ppit_pkg::DIFF_BITS'(x1) - ppit_pkg::DIFF_BITS'(x0);
	assign dy_pt    = ppit_pkg::DIFF_BITS'(py) - ppit_pkg::DIFF_BITS'(y0);
	assign straddle = (y0 > py) != (y1 > py);
	assign hit      = vld_s2 && cross_s2 && (dypos_s2 ? (p1_s2 < p2_s2) : (p1_s2 > p2_s2));

	always_ff @(posedge clk) begin
		if (is_test) begin
			pt_q <= '{x: req.point_x, y: req.point_y};
		end
		if (state_q == ppit_pkg::ST_RD_FIRST) begin
			last_q <= rdata_q;
		end
		if (state_q == ppit_pkg::ST_CHECK) begin
			prev_q <= rdata_q;
			neff_q <= (rdata_q == last_q) ? last_cnt : count_q;
		end else if (vld_s1_q) begin
			prev_q <= rdata_q;
		end
		if (state_q == ppit_pkg::ST_CHECK) begin
			walk_q <= ppit_pkg::CNT_BITS'(1);
		end else if (state_q == ppit_pkg::ST_WALK) begin
			walk_q <= walk_q + ppit_pkg::CNT_BITS'(1);
		end
		p1_s2    <= ppit_pkg::PROD_BITS'(dx_pt) * ppit_pkg::PROD_BITS'(dy_edge);
		p2_s2    <= ppit_pkg::PROD_BITS'(dx_edge) * ppit_pkg::PROD_BITS'(dy_pt);
		cross_s2 <= straddle;
		dypos_s2 <= (y1 > y0);
		if (load_out) begin
			inside_q  <= parity_q;
			ovf_out_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1_q    <= 1'b0;
			vld_s2      <= 1'b0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1_q <= (state_q == ppit_pkg::ST_WALK);
			vld_s2   <= vld_s1_q;
			if (is_test) begin
				parity_q <= 1'b0;
			end else if (hit) begin
				parity_q <= !parity_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
